>>> src/tracker_volume_column_effects_top_macros.svh
// Assertion helpers for the volume column block. Both expect clk and arst_n
// in scope at the point of use.
`ifndef TRACKER_VOLUME_COLUMN_EFFECTS_TOP_MACROS_SVH
`define TRACKER_VOLUME_COLUMN_EFFECTS_TOP_MACROS_SVH

// same-cycle implication
`define TVCE_ASSERT_NOW(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TVCE_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

>>> src/tvce_pkg.sv
package tvce_pkg;

	localparam int CHANNELS = 32;
	localparam int CH_LOG   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CH_IDX_W = (CH_LOG > 5) ? 5 : CH_LOG;

	// config register indexes
	localparam logic CFG_XM_MODE      = 1'b0;
	localparam logic CFG_SHARED_GLISS = 1'b1;

	localparam logic [6:0] VOL_MAX = 7'd64;

	typedef enum logic [2:0] {
		REQ_NONE       = 3'd0,
		REQ_VIBRATO    = 3'd1,
		REQ_GLISSANDO  = 3'd2,
		REQ_PORTA_UP   = 3'd3,
		REQ_PORTA_DOWN = 3'd4
	} req_t;

	// per-channel state
	typedef struct packed {
		logic [6:0] vol;
		logic [7:0] pan;
		logic [7:0] slide;       // XM: up high nibble, down low
		logic [7:0] fine_slide;  // XM fine slide, same layout
		logic [7:0] pan_slide;   // XM: left high nibble, right low
		logic [7:0] shared_slot; // IT slide amount, XM glissando
		logic [7:0] porta;
		logic [7:0] glide;
		logic [5:0] spd;
		logic [6:0] dep;
	} chan_t;

	typedef struct packed {
		logic [6:0] vol;
		logic [7:0] pan;
		req_t       req;
		logic [7:0] amt;
		logic [5:0] spd;
		logic [6:0] dep;
	} res_t;

	typedef struct packed {
		logic                en;
		logic [CH_IDX_W-1:0] addr;
		chan_t               data;
	} wr_t;

	function automatic logic [6:0] vol_up(input logic [6:0] v, input logic [7:0] d);
		logic [8:0] sum;
		sum = {2'b00, v} + {1'b0, d};
		return (sum > {2'b00, VOL_MAX}) ? VOL_MAX : sum[6:0];
	endfunction

	function automatic logic [6:0] vol_down(input logic [6:0] v, input logic [7:0] d);
		return (d > {1'b0, v}) ? 7'd0 : 7'({1'b0, v} - d);
	endfunction

	function automatic logic [7:0] glide_amount(input logic [3:0] idx);
		logic [7:0] r;
		case (idx)
			4'd0: r = 8'd0;
			4'd1: r = 8'd1;
			4'd2: r = 8'd4;
			4'd3: r = 8'd8;
			4'd4: r = 8'd16;
			4'd5: r = 8'd32;
			4'd6: r = 8'd64;
			4'd7: r = 8'd96;
			4'd8: r = 8'd128;
			4'd9: r = 8'd255;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

endpackage

>>> src/tracker_volume_column_effects_top.sv
// Tracker volume column effect processor, XM or IT decoding.
//
// Command channel: cmd_valid / cmd_stall carry one item (channel_index,
// command_byte, first_tick). It is taken on a rising edge with cmd_valid high
// and cmd_stall low. Result channel: res_valid / res_stall carry one item per
// command: the channel's volume, panning, vibrato settings and a pitch
// request with its amount.
// An item taken into the input register feeds the decode and per-channel
// register file read-modify-write, whose outcome loads the result register,
// which drives res_valid. One item is taken every cycle while the result is
// not stalled, back to back on the same channel too, since the state write
// and the result load share one edge.
// A stalled result holds; one more item is taken into the input register
// and cmd_stall rises only when both registers are full.
// Configuration (cfg_we, cfg_index, cfg_data) writes xm_mode or
// shared_glissando at once; write only while no item is in flight.
// Reset (arst_n low) clears the valid flags of both registers, the config and
// all per-channel state at once; no clearing pass is needed.
module tracker_volume_column_effects_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic       cfg_data,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  logic [4:0] channel_index,
	input  logic [7:0] command_byte,
	input  logic       first_tick,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [6:0] channel_volume,
	output logic [7:0] channel_panning,
	output logic [2:0] pitch_request,
	output logic [7:0] pitch_amount,
	output logic [5:0] vibrato_speed,
	output logic [6:0] vibrato_depth
);

`include "tracker_volume_column_effects_top_macros.svh"

	// configuration
	logic xm_mode_q;
	logic shared_gliss_q;

	// input stage
	logic       valid_s1;
	logic [4:0] ch_s1;
	logic [7:0] cmd_s1;
	logic       t0_s1;

	// result stage
	logic           valid_s2;
	tvce_pkg::res_t res_s2;

	logic            advance;
	logic            accept;
	logic            in_range;
	tvce_pkg::chan_t cur;
	tvce_pkg::chan_t nxt;
	tvce_pkg::res_t  res;
	tvce_pkg::wr_t   wr;

	// s1 moves on when the result register is empty or being taken
	assign advance   = !valid_s2 || !res_stall;
	assign cmd_stall = valid_s1 && !advance;
	assign accept    = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xm_mode_q      <= 1'b0;
			shared_gliss_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				tvce_pkg::CFG_XM_MODE:      xm_mode_q      <= cfg_data;
				tvce_pkg::CFG_SHARED_GLISS: shared_gliss_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!valid_s1 || advance) valid_s1 <= cmd_valid;
			if (advance) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1  <= channel_index;
			cmd_s1 <= command_byte;
			t0_s1  <= first_tick;
		end
		if (valid_s1 && advance) res_s2 <= res;
	end

	tvce_decode u_decode (
		.xm_mode       (xm_mode_q),
		.shared_gliss  (shared_gliss_q),
		.channel_index (ch_s1),
		.command_byte  (cmd_s1),
		.first_tick    (t0_s1),
		.cur           (cur),
		.nxt           (nxt),
		.res           (res),
		.in_range      (in_range)
	);

	// state write lands on the same edge the result is loaded
	assign wr.en   = valid_s1 && advance && in_range;
	assign wr.addr = ch_s1[tvce_pkg::CH_IDX_W-1:0];
	assign wr.data = nxt;

	tvce_chan_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (ch_s1[tvce_pkg::CH_IDX_W-1:0]),
		.rd_data (cur),
		.wr      (wr)
	);

	assign res_valid       = valid_s2;
	assign channel_volume  = res_s2.vol;
	assign channel_panning = res_s2.pan;
	assign pitch_request   = res_s2.req;
	assign pitch_amount    = res_s2.amt;
	assign vibrato_speed   = res_s2.spd;
	assign vibrato_depth   = res_s2.dep;

	`TVCE_ASSERT_NOW(a_stall_only_full, cmd_stall, valid_s1 && valid_s2,
		"cmd_stall raised with a free register")
	`TVCE_ASSERT_NEXT(a_s1_held, valid_s1 && !advance, valid_s1 && $stable(cmd_s1),
		"held input item lost")
	`TVCE_ASSERT_NOW(a_vol_range, valid_s2, res_s2.vol <= tvce_pkg::VOL_MAX,
		"channel volume above 64")
	`TVCE_ASSERT_NOW(a_vib_no_amount, valid_s2 && res_s2.req == tvce_pkg::REQ_VIBRATO,
		res_s2.amt == 8'd0, "vibrato request with nonzero amount")

endmodule

>>> src/tvce_chan_regs.sv
// Per-channel state register file, cleared at reset.
module tvce_chan_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [tvce_pkg::CH_IDX_W-1:0]     rd_addr,
	output tvce_pkg::chan_t                   rd_data,
	input  tvce_pkg::wr_t                     wr
);

	tvce_pkg::chan_t regs_q [tvce_pkg::CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tvce_pkg::CHANNELS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (wr.en) begin
			regs_q[wr.addr] <= wr.data;
		end
	end

	assign rd_data = regs_q[rd_addr];

endmodule

>>> src/tvce_decode.sv
// Command decode and state update for one channel, XM or IT.
module tvce_decode (
	input  logic            xm_mode,
	input  logic            shared_gliss,
	input  logic [4:0]      channel_index,
	input  logic [7:0]      command_byte,
	input  logic            first_tick,
	input  tvce_pkg::chan_t cur,
	output tvce_pkg::chan_t nxt,
	output tvce_pkg::res_t  res,
	output logic            in_range
);

	always_comb begin
		logic [7:0] c;
		logic [3:0] x;
		logic [3:0] nib;
		logic [7:0] mem;
		logic [7:0] off;
		logic [7:0] a;
		logic [7:0] val;
		logic [5:0] sh;
		logic [8:0] sum;
		logic       fine;
		logic       up;
		tvce_pkg::req_t req;

		c    = command_byte;
		x    = c[3:0];
		nib  = '0;
		mem  = '0;
		off  = '0;
		a    = '0;
		val  = '0;
		sh   = '0;
		sum  = '0;
		fine = 1'b0;
		up   = 1'b0;
		req  = tvce_pkg::REQ_NONE;
		nxt  = cur;

		if (xm_mode) begin
			if (c >= 8'h10 && c <= 8'h50) begin
				if (first_tick) nxt.vol = 7'(c - 8'h10);
			end else if (c >= 8'h60 && c < 8'hA0) begin
				fine = c[7];
				up   = c[4];
				mem  = fine ? cur.fine_slide : cur.slide;
				if (first_tick == fine) begin
					if (up) begin
						nib     = (x == 4'd0) ? mem[7:4] : x;
						mem     = {nib, mem[3:0]};
						nxt.vol = tvce_pkg::vol_up(cur.vol, {4'd0, nib});
					end else begin
						nib     = (x == 4'd0) ? mem[3:0] : x;
						mem     = {mem[7:4], nib};
						nxt.vol = tvce_pkg::vol_down(cur.vol, {4'd0, nib});
					end
					if (fine) nxt.fine_slide = mem;
					else nxt.slide = mem;
				end
			end else if (c >= 8'hA0 && c < 8'hC0) begin
				if (!first_tick) begin
					if (!c[4]) begin
						if (x != 4'd0) nxt.spd = {x, 2'b00};
					end else begin
						if (x != 4'd0) nxt.dep = {x, 3'b000};
					end
					req = tvce_pkg::REQ_VIBRATO;
				end
			end else if (c >= 8'hC0 && c < 8'hD0) begin
				if (first_tick) nxt.pan = (x == 4'hF) ? 8'd255 : {x, 4'h0};
			end else if (c >= 8'hD0 && c < 8'hF0) begin
				if (!first_tick) begin
					mem = cur.pan_slide;
					if (c < 8'hE0) begin
						// slide left, high nibble
						nib     = (x == 4'd0) ? mem[7:4] : x;
						nxt.pan_slide = {nib, mem[3:0]};
						sh      = {nib, 2'b00};
						nxt.pan = ({2'b00, sh} > cur.pan) ? 8'd0 : 8'(cur.pan - {2'b00, sh});
					end else begin
						nib     = (x == 4'd0) ? mem[3:0] : x;
						nxt.pan_slide = {mem[7:4], nib};
						sh      = {nib, 2'b00};
						sum     = {1'b0, cur.pan} + {3'b000, sh};
						nxt.pan = sum[8] ? 8'd255 : sum[7:0];
					end
				end
			end else if (c >= 8'hF0) begin
				if (!first_tick) begin
					a   = {x, 4'h0};
					val = (a == 8'd0) ? cur.shared_slot : a;
					nxt.shared_slot = val;
					req = tvce_pkg::REQ_GLISSANDO;
				end
			end
		end else begin
			if (c <= 8'd64) begin
				if (first_tick) nxt.vol = c[6:0];
			end else if (c <= 8'd104) begin
				fine = (c <= 8'd84);
				off  = c - (fine ? 8'd65 : 8'd85);
				up   = (off < 8'd10);
				if (first_tick == fine) begin
					a   = up ? off : off - 8'd10;
					val = (a == 8'd0) ? cur.shared_slot : a;
					nxt.shared_slot = val;
					nxt.vol = up ? tvce_pkg::vol_up(cur.vol, val)
						: tvce_pkg::vol_down(cur.vol, val);
				end
			end else if (c <= 8'd124) begin
				if (!first_tick) begin
					up  = (c >= 8'd115);
					a   = 8'((c - (up ? 8'd115 : 8'd105)) << 2);
					val = (a == 8'd0) ? cur.porta : a;
					nxt.porta = val;
					req = up ? tvce_pkg::REQ_PORTA_UP : tvce_pkg::REQ_PORTA_DOWN;
				end
			end else if (c >= 8'd128 && c <= 8'd192) begin
				if (first_tick) begin
					sum     = {c[6:0], 2'b00};
					nxt.pan = sum[8] ? 8'd255 : sum[7:0];
				end
			end else if (c >= 8'd193 && c <= 8'd202) begin
				if (!first_tick) begin
					a = tvce_pkg::glide_amount(4'(c - 8'd193));
					if (shared_gliss) begin
						val = (a == 8'd0) ? cur.porta : a;
						nxt.porta = val;
					end else begin
						val = (a == 8'd0) ? cur.glide : a;
					end
					nxt.glide = val;
					req = tvce_pkg::REQ_GLISSANDO;
				end
			end else if (c >= 8'd203 && c <= 8'd212) begin
				if (!first_tick) begin
					a = c - 8'd203;
					if (a != 8'd0) nxt.spd = {a[3:0], 2'b00};
					req = tvce_pkg::REQ_VIBRATO;
				end
			end
		end

		in_range = (int'(channel_index) < tvce_pkg::CHANNELS);

		if (in_range) begin
			res.vol = nxt.vol;
			res.pan = nxt.pan;
			res.req = req;
			// amount only goes out with a glissando or porta request
			res.amt = (req == tvce_pkg::REQ_NONE || req == tvce_pkg::REQ_VIBRATO)
				? 8'd0 : val;
			res.spd = nxt.spd;
			res.dep = nxt.dep;
		end else begin
			res = '0;
		end
	end

endmodule

>>> tb/tb_tracker_volume_column_effects_top.sv
`timescale 1ns / 100ps

module tb_tracker_volume_column_effects_top;

	// one command item as the sender offers it
	typedef struct {
		logic [4:0] ch;
		logic [7:0] cmd;
		logic       t0;
	} cmd_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_index = 1'b0;
	logic       cfg_data = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	logic [4:0] channel_index = '0;
	logic [7:0] command_byte = '0;
	logic       first_tick = 1'b0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [6:0] channel_volume;
	logic [7:0] channel_panning;
	logic [2:0] pitch_request;
	logic [7:0] pitch_amount;
	logic [5:0] vibrato_speed;
	logic [6:0] vibrato_depth;

	tracker_volume_column_effects_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.channel_index(channel_index),
		.command_byte(command_byte),
		.first_tick(first_tick),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.channel_volume(channel_volume),
		.channel_panning(channel_panning),
		.pitch_request(pitch_request),
		.pitch_amount(pitch_amount),
		.vibrato_speed(vibrato_speed),
		.vibrato_depth(vibrato_depth)
	);

	always #2 clk = ~clk;

	// Shadow copy of the block's configuration and per-channel state.
	logic       cfg_xm = 1'b0;
	logic       cfg_shared = 1'b0;
	logic [6:0] vol_mem [tvce_pkg::CHANNELS];
	logic [7:0] pan_mem [tvce_pkg::CHANNELS];
	logic [7:0] slide_nib [tvce_pkg::CHANNELS];     // XM slide: up high nibble, down low
	logic [7:0] fine_nib [tvce_pkg::CHANNELS];      // XM fine slide, same layout
	logic [7:0] panslide_nib [tvce_pkg::CHANNELS];  // XM pan slide: left high, right low
	logic [7:0] slot_mem [tvce_pkg::CHANNELS];      // IT slide amount / XM glissando
	logic [7:0] porta_mem [tvce_pkg::CHANNELS];
	logic [7:0] gliss_mem [tvce_pkg::CHANNELS];
	logic [5:0] vib_speed [tvce_pkg::CHANNELS];
	logic [6:0] vib_depth [tvce_pkg::CHANNELS];

	cmd_item_t      pending_cmds[$];     // items not yet offered to the block
	tvce_pkg::res_t expected_results[$]; // one per accepted item, oldest first
	cmd_item_t      next_cmd;
	tvce_pkg::res_t want;

	int mismatch_count = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_requests = 0;  // bumped by the sequence to ask for a long result hold-off
	int holds_served = 0;
	bit no_idle = 1'b0;     // both sides run flat out while set

	initial begin
		for (int i = 0; i < tvce_pkg::CHANNELS; i++) begin
			vol_mem[i] = '0; pan_mem[i] = '0; slide_nib[i] = '0; fine_nib[i] = '0;
			panslide_nib[i] = '0; slot_mem[i] = '0; porta_mem[i] = '0;
			gliss_mem[i] = '0; vib_speed[i] = '0; vib_depth[i] = '0;
		end
	end

	// Zero amount recalls what is remembered; caller stores the returned value,
	// which leaves the memory unchanged on a recall.
	function automatic int remembered(input logic [7:0] stored, input int amount);
		return (amount == 0) ? int'(stored) : amount;
	endfunction

	function automatic int raise_volume(input int v, input int d);
		return (v + d > 64) ? 64 : v + d;
	endfunction

	function automatic int lower_volume(input int v, input int d);
		return (d > v) ? 0 : v - d;
	endfunction

	// Applies one command to the shadow state and returns the item the block
	// should produce for it.
	function automatic tvce_pkg::res_t apply_command(input logic [4:0] ch,
			input logic [7:0] c, input logic t0);
		tvce_pkg::res_t r;
		int             vol, pan, amt, spd, dep, x, off;
		tvce_pkg::req_t req;
		logic           fine, up;
		logic [7:0]     mem;
		r = '0;
		if (ch >= tvce_pkg::CHANNELS)
			return r;
		vol = vol_mem[ch];
		pan = pan_mem[ch];
		spd = vib_speed[ch];
		dep = vib_depth[ch];
		req = tvce_pkg::REQ_NONE;
		amt = 0;
		x = c[3:0];
		if (cfg_xm) begin
			if (c >= 8'h10 && c <= 8'h50) begin
				if (t0)
					vol = c - 8'h10;
			end else if (c >= 8'h60 && c < 8'hA0) begin
				// normal slides run on later ticks, fine slides on the first
				fine = c >= 8'h80;
				up = c[4];
				if (t0 == fine) begin
					mem = fine ? fine_nib[ch] : slide_nib[ch];
					if (up) begin
						if (x == 0) x = mem[7:4]; else mem[7:4] = x[3:0];
						vol = raise_volume(vol, x);
					end else begin
						if (x == 0) x = mem[3:0]; else mem[3:0] = x[3:0];
						vol = lower_volume(vol, x);
					end
					if (fine) fine_nib[ch] = mem; else slide_nib[ch] = mem;
				end
			end else if (c >= 8'hA0 && c < 8'hC0) begin
				if (!t0) begin
					if (c < 8'hB0) begin
						if (x != 0) spd = x << 2;
					end else if (x != 0)
						dep = x << 3;
					req = tvce_pkg::REQ_VIBRATO;
				end
			end else if (c >= 8'hC0 && c < 8'hD0) begin
				if (t0)
					pan = (x == 15) ? 255 : x << 4;
			end else if (c >= 8'hD0 && c < 8'hF0) begin
				if (!t0) begin
					mem = panslide_nib[ch];
					if (c < 8'hE0) begin
						if (x == 0) x = mem[7:4]; else mem[7:4] = x[3:0];
						x = x << 2;
						pan = (x > pan) ? 0 : pan - x;
					end else begin
						if (x == 0) x = mem[3:0]; else mem[3:0] = x[3:0];
						pan = pan + (x << 2);
						if (pan > 255) pan = 255;
					end
					panslide_nib[ch] = mem;
				end
			end else if (c >= 8'hF0) begin
				if (!t0) begin
					amt = remembered(slot_mem[ch], x << 4);
					slot_mem[ch] = amt[7:0];
					req = tvce_pkg::REQ_GLISSANDO;
				end
			end
		end else begin
			if (c <= 64) begin
				if (t0)
					vol = c;
			end else if (c <= 104) begin
				fine = c <= 84;
				off = c - (fine ? 65 : 85);
				up = off < 10;
				if (t0 == fine) begin
					x = remembered(slot_mem[ch], up ? off : off - 10);
					slot_mem[ch] = x[7:0];
					vol = up ? raise_volume(vol, x) : lower_volume(vol, x);
				end
			end else if (c <= 124) begin
				if (!t0) begin
					up = c >= 115;
					x = (c - (up ? 115 : 105)) << 2;
					amt = remembered(porta_mem[ch], x);
					porta_mem[ch] = amt[7:0];
					req = up ? tvce_pkg::REQ_PORTA_UP : tvce_pkg::REQ_PORTA_DOWN;
				end
			end else if (c >= 128 && c <= 192) begin
				if (t0) begin
					pan = (c - 128) << 2;
					if (pan > 255) pan = 255;
				end
			end else if (c >= 193 && c <= 202) begin
				if (!t0) begin
					case (c - 193)
						0: x = 0;
						1: x = 1;
						2: x = 4;
						3: x = 8;
						4: x = 16;
						5: x = 32;
						6: x = 64;
						7: x = 96;
						8: x = 128;
						default: x = 255;
					endcase
					if (cfg_shared) begin
						amt = remembered(porta_mem[ch], x);
						porta_mem[ch] = amt[7:0];
					end else
						amt = remembered(gliss_mem[ch], x);
					gliss_mem[ch] = amt[7:0];
					req = tvce_pkg::REQ_GLISSANDO;
				end
			end else if (c >= 203 && c <= 212) begin
				if (!t0) begin
					x = c - 203;
					if (x != 0) spd = x << 2;
					req = tvce_pkg::REQ_VIBRATO;
				end
			end
		end
		vol_mem[ch] = vol[6:0];
		pan_mem[ch] = pan[7:0];
		vib_speed[ch] = spd[5:0];
		vib_depth[ch] = dep[6:0];
		r.vol = vol[6:0];
		r.pan = pan[7:0];
		r.req = req;
		r.amt = amt[7:0];
		r.spd = spd[5:0];
		r.dep = dep[6:0];
		return r;
	endfunction

	// Mostly no gap, some short, a few long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Driver: prediction happens at the edge the item is taken, so the
	// expected queue stays in acceptance order. A stalled item is held as is.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				expected_results.push_back(apply_command(channel_index, command_byte,
					first_tick));
			if (!cmd_valid || !cmd_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					cmd_valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					next_cmd = pending_cmds.pop_front();
					channel_index <= next_cmd.ch;
					command_byte <= next_cmd.cmd;
					first_tick <= next_cmd.t0;
					cmd_valid <= 1'b1;
					send_gap = no_idle ? 0 : idle_len();
				end else
					cmd_valid <= 1'b0;
			end
		end
	end

	task automatic check_field(input string what, input int want_v, input int got_v);
		if (want_v != got_v) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v,
				got_v);
		end
	endtask

	// Monitor: checks every taken result against the oldest prediction and
	// drives res_stall, including the long hold-off the sequence asks for.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result, expected none, actual vol %0d pan %0d",
						$time, channel_volume, channel_panning);
				end else begin
					want = expected_results.pop_front();
					check_field("channel_volume", want.vol, channel_volume);
					check_field("channel_panning", want.pan, channel_panning);
					check_field("pitch_request", want.req, pitch_request);
					check_field("pitch_amount", want.amt, pitch_amount);
					check_field("vibrato_speed", want.spd, vibrato_speed);
					check_field("vibrato_depth", want.dep, vibrato_depth);
				end
			end
			if (holds_served != hold_requests) begin
				holds_served++;
				recv_gap = 120;
			end
			if (recv_gap > 0) begin
				recv_gap--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
				recv_gap = no_idle ? 0 : idle_len();
			end
		end
	end

	task automatic queue_cmd(input int ch, input int cmd, input bit t0);
		cmd_item_t it;
		it.ch = ch[4:0];
		it.cmd = cmd[7:0];
		it.t0 = t0;
		pending_cmds.push_back(it);
	endtask

	// Sender is out of items, nothing in flight and every result is back;
	// then the two-stage pipe is left to settle.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_cmds.size() != 0 || cmd_valid || expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(input logic idx, input logic val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == tvce_pkg::CFG_XM_MODE)
			cfg_xm = val;
		else
			cfg_shared = val;
	endtask

	// State builds up on hot channels 0 to 3 so recalls see real values.
	function automatic int rand_channel();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
	endfunction

	function automatic int rand_it_cmd();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 64);
			1: return $urandom_range(65, 104);
			2: return $urandom_range(105, 124);
			3: return $urandom_range(128, 192);
			4: return $urandom_range(193, 202);
			5: return $urandom_range(203, 212);
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	// XM: any high nibble, low nibble zero at least a quarter of the time to hit recalls
	function automatic int rand_xm_cmd();
		int lo;
		lo = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
		return $urandom_range(0, 15) * 16 + lo;
	endfunction

	// Queues random items; every 60 the sender waits for all results.
	task automatic queue_random(input int count);
		for (int n = 0; n < count; n++) begin
			queue_cmd(rand_channel(), cfg_xm ? rand_xm_cmd() : rand_it_cmd(),
				$urandom_range(0, 1));
			if (n % 60 == 59 || n == count - 1)
				wait_drained();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// IT, separate glissando memory (reset config): set, fine and normal
		// slides with recall, porta both ways, pan saturation, glissando
		// recall, vibrato speed kept on zero, an unused code.
		queue_cmd(0, 64, 1);  queue_cmd(0, 74, 1);  queue_cmd(0, 84, 1);
		queue_cmd(0, 85, 0);  queue_cmd(0, 104, 0); queue_cmd(0, 114, 0);
		queue_cmd(0, 115, 0); queue_cmd(0, 192, 1); queue_cmd(0, 202, 0);
		queue_cmd(0, 193, 0); queue_cmd(0, 212, 0); queue_cmd(0, 203, 0);
		queue_cmd(31, 255, 0);
		wait_drained();

		// IT, glissando shares the porta memory
		write_cfg(tvce_pkg::CFG_SHARED_GLISS, 1'b1);
		queue_cmd(31, 110, 0); queue_cmd(31, 193, 0); queue_cmd(31, 200, 0);
		queue_random(130);

		// XM: directed pass over each command group, then random traffic
		// opening with a long result hold-off so the block backs up.
		write_cfg(tvce_pkg::CFG_XM_MODE, 1'b1);
		queue_cmd(0, 8'h50, 1); queue_cmd(0, 8'h6F, 0); queue_cmd(0, 8'h60, 0);
		queue_cmd(0, 8'h7F, 0); queue_cmd(0, 8'h8A, 1); queue_cmd(0, 8'h90, 1);
		queue_cmd(0, 8'hAF, 0); queue_cmd(0, 8'hBF, 0); queue_cmd(0, 8'hCF, 1);
		queue_cmd(0, 8'hDF, 0); queue_cmd(0, 8'hE0, 0); queue_cmd(0, 8'hFF, 0);
		queue_cmd(31, 8'h05, 1);
		wait_drained();
		hold_requests++;
		queue_random(140);

		// back to IT with separate memories; first stretch runs without gaps
		write_cfg(tvce_pkg::CFG_XM_MODE, 1'b0);
		write_cfg(tvce_pkg::CFG_SHARED_GLISS, 1'b0);
		no_idle = 1'b1;
		queue_random(60);
		no_idle = 1'b0;
		queue_random(80);

		write_cfg(tvce_pkg::CFG_XM_MODE, 1'b1);
		queue_random(140);

		// catch any stray result after the last one
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
